[src/sdiv_pkg.sv]
// ============================================================================
// sdiv_pkg
// Shared types and constants for the signed restoring divider.
// ============================================================================
package sdiv_pkg;

    localparam int DEF_DATA_WIDTH = 32;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIX
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic fix;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

[src/sdiv_dp.sv]
// ============================================================================
// sdiv_dp
// Datapath: operand magnitudes, shift-and-subtract remainder loop, sign
// fix-up and the result register.
// ============================================================================
module sdiv_dp
    import sdiv_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] quotient,
    output status_t               status
);

    localparam logic [DATA_WIDTH-1:0] MAXPOS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] nq_reg, nq_next;
    logic [DATA_WIDTH-1:0] dm_reg, dm_next;
    logic                  flip_reg, flip_next;
    logic                  dz_reg, dz_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] quot_reg, quot_next;
    status_t               status_reg, status_next;

    logic                  n_neg, d_neg;
    logic [DATA_WIDTH:0]   rem_sh;
    logic                  ge;

    assign n_neg  = dividend[DATA_WIDTH-1];
    assign d_neg  = divisor[DATA_WIDTH-1];
    assign rem_sh = {rem_reg, nq_reg[DATA_WIDTH-1]};
    assign ge     = (rem_sh >= {1'b0, dm_reg});

    assign stat.out_free = !out_valid_reg || out_ready;

    always_comb begin
        rem_next       = rem_reg;
        nq_next        = nq_reg;
        dm_next        = dm_reg;
        flip_next      = flip_reg;
        dz_next        = dz_reg;
        out_valid_next = out_valid_reg;
        quot_next      = quot_reg;
        status_next    = status_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.load) begin
            rem_next  = '0;
            nq_next   = n_neg ? (~dividend + 1'b1) : dividend;
            dm_next   = d_neg ? (~divisor + 1'b1) : divisor;
            flip_next = n_neg ^ d_neg;
            dz_next   = (divisor == '0);
        end
        if (cmd.step) begin
            // The shifted dividend bit leaves the top while the quotient bit enters below.
            rem_next = ge ? DATA_WIDTH'(rem_sh - {1'b0, dm_reg}) : rem_sh[DATA_WIDTH-1:0];
            nq_next  = {nq_reg[DATA_WIDTH-2:0], ge};
        end
        if (cmd.fix) begin
            out_valid_next = 1'b1;
            if (dz_reg) begin
                quot_next   = '0;
                status_next = ST_DIV0;
            end else if (flip_reg) begin
                quot_next   = ~nq_reg + 1'b1;
                status_next = ST_OK;
            end else if (nq_reg[DATA_WIDTH-1]) begin
                quot_next   = MAXPOS;
                status_next = ST_OVF;
            end else begin
                quot_next   = nq_reg;
                status_next = ST_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        rem_reg    <= rem_next;
        nq_reg     <= nq_next;
        dm_reg     <= dm_next;
        flip_reg   <= flip_next;
        dz_reg     <= dz_next;
        quot_reg   <= quot_next;
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign quotient  = quot_reg;
    assign status    = status_reg;

    a_fix_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fix |-> stat.out_free)
        else $error("result written while the output register is still occupied");

    a_load_step_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load && (cmd.step || cmd.fix)))
        else $error("load command overlaps a step or fix command");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(quot_reg)))
        else $error("pending result changed before it was taken");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (status_reg == ST_OK || status_reg == ST_DIV0
                           || status_reg == ST_OVF))
        else $error("result carries an undefined status code");

endmodule

[src/sdiv_ctrl.sv]
// ============================================================================
// sdiv_ctrl
// Controller: sequences operand load, one step per quotient bit and the
// final sign fix-up into the result register.
// ============================================================================
module sdiv_ctrl
    import sdiv_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = S_RUN;
                    cnt_next   = CNT_W'(DATA_WIDTH - 1);
                end
            end
            S_RUN: begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_FIX;
                end
            end
            S_FIX: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_RUN: begin
                cmd.step = 1'b1;
            end
            S_FIX: begin
                cmd.fix = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_last_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN && cnt_reg == '0) |=> (state_reg == S_FIX))
        else $error("final quotient step did not lead to fix-up");

    a_load_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == S_RUN && cnt_reg == CNT_W'(DATA_WIDTH - 1)))
        else $error("step counter not primed after operand load");

endmodule

[src/signed_restoring_divider.sv]
// ============================================================================
// signed_restoring_divider
// Signed integer divider, quotient truncated toward zero, radix-2 restoring.
// ============================================================================
// Each input transaction on the s_ channel carries a dividend and a divisor;
// each one yields exactly one output transaction on the m_ channel with the
// quotient in m_tdata and a status code in m_tuser (0 ok, 1 divide by zero,
// 2 overflow, in which case the quotient is the largest positive value).
// A division loads the operand magnitudes at acceptance, then runs one step per
// quotient bit in the shared subtract-and-compare unit and a final sign fix-up.
// One division is in flight at a time; s_tready is high while the unit is idle.
// The result sits in an output register, so a new transaction is accepted
// while an earlier result still waits on m_tready. If the receiver stalls,
// the next division finishes and holds in the fix-up step until the output
// register frees up. Reset clears the controller and the output valid; no
// result is lost or repeated under any stall pattern.
// ============================================================================
module signed_restoring_divider
    import sdiv_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,  // dividend, divisor
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]        m_tdata,  // quotient
    output logic [1:0]                             m_tuser   // status
);

    localparam int ODATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    dp_cmd_t               cmd;
    dp_stat_t              stat;
    logic [DATA_WIDTH-1:0] quotient;
    status_t               status;

    sdiv_ctrl #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    sdiv_dp #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .dividend  (s_tdata[DATA_WIDTH-1:0]),
        .divisor   (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .quotient  (quotient),
        .status    (status)
    );

    assign m_tdata = ODATA_W'(quotient);
    assign m_tuser = status;

endmodule
